FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/csbm_pkg.sv
package csbm_pkg;
   localparam int ELEM_BITS   = 16;
   localparam int MAX_VEC_LEN = 512;
   localparam int ACC_W  = 48;
   localparam int PROD_W = 96;
   localparam int LIM_W  = 126;
   localparam int SIM_W  = 16;
   localparam int IDX_W  = 10;

   typedef struct packed {
      logic signed [ACC_W-1:0] dot;
      logic [ACC_W-1:0]        qn;
      logic [ACC_W-1:0]        kn;
      logic                    last_key;
   } vec_sums_type;

   typedef struct packed {
      logic signed [SIM_W-1:0] sim;
      logic [IDX_W-1:0]        key_index;
      logic [IDX_W-1:0]        best_index;
      logic signed [SIM_W-1:0] best_sim;
      logic                    done;
   } result_type;

   localparam logic signed [SIM_W-1:0] SCORE_RESET = 16'sh8000;
endpackage

FILE: design/csbm_accum.sv
// Front part: accumulate dot product and both norms, saturating.
module csbm_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [csbm_pkg::ELEM_BITS-1:0] q,
   input  logic signed [csbm_pkg::ELEM_BITS-1:0] k,
   input  logic                                last_elem,
   input  logic                                last_key,
   output logic                                out_valid,
   input  logic                                out_ready,
   output csbm_pkg::vec_sums_type              out_sums
);
   import csbm_pkg::*;

   localparam int PW = 2*ELEM_BITS;
   localparam logic signed [ACC_W:0] POS_MAX = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W:0] NEG_MIN = {2'b11, {(ACC_W-1){1'b0}}};

   logic signed [ACC_W-1:0] dot_ff, dot_in;
   logic [ACC_W-1:0] qn_ff, qn_in, kn_ff, kn_in;
   logic signed [PW-1:0] pd, pq, pk;
   logic signed [ACC_W:0] dsum;
   logic [ACC_W:0] qsum, ksum;
   logic take, emit;

   // Result queue holds one entry; accept while it is free or draining.
   logic             pend_ff;
   vec_sums_type     pend_data_ff;

   assign in_ready  = !pend_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign emit      = take && last_elem;
   assign out_valid = pend_ff;
   assign out_sums  = pend_data_ff;

   always_comb begin
      pd   = PW'(q) * PW'(k);
      pq   = PW'(q) * PW'(q);
      pk   = PW'(k) * PW'(k);
      dsum = (ACC_W+1)'(dot_ff) + (ACC_W+1)'(pd);
      qsum = (ACC_W+1)'(qn_ff) + (ACC_W+1)'($unsigned(pq));
      ksum = (ACC_W+1)'(kn_ff) + (ACC_W+1)'($unsigned(pk));
      if (dsum > POS_MAX) dot_in = POS_MAX[ACC_W-1:0];
      else if (dsum < NEG_MIN) dot_in = NEG_MIN[ACC_W-1:0];
      else dot_in = dsum[ACC_W-1:0];
      qn_in = qsum[ACC_W] ? {ACC_W{1'b1}} : qsum[ACC_W-1:0];
      kn_in = ksum[ACC_W] ? {ACC_W{1'b1}} : ksum[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         qn_ff   <= '0;
         kn_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (take) begin
            dot_ff <= emit ? '0 : dot_in;
            qn_ff  <= emit ? '0 : qn_in;
            kn_ff  <= emit ? '0 : kn_in;
         end
         if (emit) pend_ff <= 1'b1;
         else if (out_ready) pend_ff <= 1'b0;
      end
      if (emit) begin
         pend_data_ff.dot      <= dot_in;
         pend_data_ff.qn       <= qn_in;
         pend_data_ff.kn       <= kn_in;
         pend_data_ff.last_key <= last_key;
      end
   end
endmodule

FILE: design/csbm_fifo.sv
// Short queue between accumulator and similarity unit.
module csbm_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  csbm_pkg::vec_sums_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output csbm_pkg::vec_sums_type out_data
);
   import csbm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   vec_sums_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

FILE: design/csbm_cosine.sv
// Back part: cosine by a bit-at-a-time search for m, then best-key update.
module csbm_cosine #(
   parameter int MAX_KEYS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  csbm_pkg::vec_sums_type in_sums,
   output logic                   out_valid,
   input  logic                   out_ready,
   output csbm_pkg::result_type   out_res
);
   import csbm_pkg::*;

   localparam int CW = LIM_W + 2;

   localparam logic [IDX_W-1:0] KEY_LIMIT =
      (MAX_KEYS - 1 > 1023) ? IDX_W'(1023) : IDX_W'(MAX_KEYS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] st_ff;
   logic [ACC_W-1:0] a_ff, b_ff;          // multiplier operands
   logic [1:0]  ph_ff;                    // partial product phase
   logic [PROD_W-1:0] acc_ff;             // partial product sum
   logic [PROD_W-1:0] prod_ff;            // qn*kn
   logic [LIM_W-1:0]  lim_ff;             // dot^2 * 2^30
   logic neg_ff, zero_ff, lk_ff, lim_done_ff, ov_ff;
   logic [SIM_W-1:0] m_ff;                // magnitude found so far
   logic [3:0]  bit_ff;
   logic [LIM_W-1:0] mp_ff;               // m * prod
   logic [LIM_W-1:0] mp2_ff;              // m^2 * prod
   logic [LIM_W-1:0] mpn_ff;              // (m + 2^bit) * prod
   logic [CW-1:0] cand_ff;                // (m + 2^bit)^2 * prod
   logic [SIM_W-1:0] sim_r;
   logic [IDX_W-1:0] kc_ff, bk_ff;
   logic signed [SIM_W-1:0] bs_ff;
   result_type res;
   logic [23:0] pa, pb;
   logic [47:0] pp;
   logic [PROD_W-1:0] pp_sh, mul_sum;
   logic [CW-1:0] cand_in;
   logic [LIM_W-1:0] mpn_in;
   logic [SIM_W-1:0] trial;
   logic fit, better;

   // 48x48 as four 24x24 partial products, one per cycle.
   always_comb begin
      pa = ph_ff[1] ? a_ff[47:24] : a_ff[23:0];
      pb = ph_ff[0] ? b_ff[47:24] : b_ff[23:0];
      pp = pa * pb;
      pp_sh = PROD_W'(pp) << (24 * ({1'b0, ph_ff[1]} + {1'b0, ph_ff[0]}));
      mul_sum = acc_ff + pp_sh;
      // (m + 2^b)^2 * P = m^2*P + m*P*2^(b+1) + P*2^(2b)
      trial = 16'd1 << bit_ff;
      cand_in = CW'(mp2_ff) + (CW'(mp_ff) << ({1'b0, bit_ff} + 5'd1))
              + (CW'(prod_ff) << {bit_ff, 1'b0});
      mpn_in = mp_ff + (LIM_W'(prod_ff) << bit_ff);
      fit = cand_ff <= CW'(lim_ff);
   end

   assign in_ready  = st_ff == S_IDLE;
   assign out_valid = st_ff == S_OUT;
   assign out_res   = res;

   always_comb begin
      if (zero_ff) sim_r = '0;
      else if (ov_ff) sim_r = neg_ff ? 16'h8000 : 16'h7FFF;
      else if (neg_ff) sim_r = -m_ff;
      else sim_r = m_ff;
      better = $signed(sim_r) > bs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         kc_ff <= '0;
         bk_ff <= '0;
         bs_ff <= SCORE_RESET;
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (in_valid) begin
                  neg_ff  <= in_sums.dot[ACC_W-1];
                  a_ff    <= in_sums.dot[ACC_W-1] ? ACC_W'(-in_sums.dot) : in_sums.dot;
                  b_ff    <= in_sums.dot[ACC_W-1] ? ACC_W'(-in_sums.dot) : in_sums.dot;
                  zero_ff <= (in_sums.qn == '0) || (in_sums.kn == '0);
                  lk_ff   <= in_sums.last_key;
                  prod_ff <= {in_sums.qn, in_sums.kn}; // park operands
                  ph_ff   <= 2'd0;
                  acc_ff  <= '0;
                  lim_done_ff <= 1'b0;
                  st_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff != 2'd3) begin
                  acc_ff <= mul_sum;
               end else if (!lim_done_ff) begin
                  lim_ff <= {mul_sum, 30'b0};
                  lim_done_ff <= 1'b1;
                  a_ff <= prod_ff[PROD_W-1:ACC_W];
                  b_ff <= prod_ff[ACC_W-1:0];
                  acc_ff <= '0;
               end else begin
                  prod_ff <= mul_sum;
                  m_ff   <= '0;
                  ov_ff  <= 1'b0;
                  mp_ff  <= '0;
                  mp2_ff <= '0;
                  bit_ff <= 4'd15;
                  st_ff  <= S_SRCH;
               end
            end
            S_SRCH: begin
               cand_ff <= cand_in;
               mpn_ff  <= mpn_in;
               st_ff   <= S_CMP;
            end
            S_CMP: begin
               if (fit && bit_ff == 4'd15) begin
                  // magnitude reaches one: clamp and stop
                  ov_ff <= 1'b1;
                  st_ff <= S_OUT;
               end else begin
                  if (fit) begin
                     m_ff   <= m_ff | trial;
                     mp2_ff <= cand_ff[LIM_W-1:0];
                     mp_ff  <= mpn_ff;
                  end
                  if (bit_ff == 4'd0) begin
                     st_ff <= S_OUT;
                  end else begin
                     bit_ff <= bit_ff - 4'd1;
                     st_ff  <= S_SRCH;
                  end
               end
            end
            S_OUT: begin
               if (out_ready) begin
                  if (lk_ff) begin
                     kc_ff <= '0;
                     bk_ff <= '0;
                     bs_ff <= SCORE_RESET;
                  end else begin
                     if (better) begin
                        bs_ff <= sim_r;
                        bk_ff <= kc_ff;
                     end
                     if (kc_ff < KEY_LIMIT) kc_ff <= kc_ff + 1'b1;
                  end
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // Result fields track the search; best is folded in combinationally.
   always_comb begin
      res.sim        = sim_r;
      res.key_index  = kc_ff;
      res.best_index = better ? kc_ff : bk_ff;
      res.best_sim   = better ? sim_r : bs_ff;
      res.done       = lk_ff;
   end
endmodule

FILE: design/cosine_similarity_best_match_core.sv
// Channel | Ports    | tdata fields (low bit up)                              | tlast / tuser
// req     | req_t*   | query_elem[15:0], key_elem[31:16], last_key[32], pad   | tlast = last_elem
// rsp     | rsp_t*   | similarity, key_index, best_index, best_similarity, pad| tuser = search_done
//
// One element pair is taken per cycle while the front has room; the
// accumulator is a single saturating MAC stage.
// Each finished vector passes through the cosine unit as 24x24 partial products
// for dot^2 and then qn*kn, then a 16-step magnitude search with a search and
// a compare state per bit; the search stops early when the magnitude clamps at one.
// Vectors long enough to cover that work stream at full rate; shorter ones fill
// the one-entry hold and the four-entry queue, then drop req_tready.
// A stalled rsp transfer holds the cosine unit.
// Reset is synchronous and clears sums, queue, key counter and best key.
module cosine_similarity_best_match_core #(
   parameter int MAX_KEYS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // query_elem, key_elem, last_key, zero pad
   input  logic        req_tlast,   // last_elem
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // similarity, key_index, best_index, best_similarity, pad
   output logic        rsp_tuser    // search_done
);
   import csbm_pkg::*;

   logic a_v, a_r, f_v, f_r;
   vec_sums_type a_d, f_d;
   result_type res;

   // accumulate element pairs
   csbm_accum u_acc (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .q(req_tdata[15:0]), .k(req_tdata[31:16]),
      .last_elem(req_tlast), .last_key(req_tdata[32]),
      .out_valid(a_v), .out_ready(a_r), .out_sums(a_d)
   );

   // hold finished sums until the cosine unit is free
   csbm_fifo #(.DEPTH(4)) u_q (
      .clock, .reset,
      .in_valid(a_v), .in_ready(a_r), .in_data(a_d),
      .out_valid(f_v), .out_ready(f_r), .out_data(f_d)
   );

   csbm_cosine #(.MAX_KEYS(MAX_KEYS)) u_cos (
      .clock, .reset,
      .in_valid(f_v), .in_ready(f_r), .in_sums(f_d),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {4'b0, res.best_sim, res.best_index, res.key_index, res.sim};
   assign rsp_tuser = res.done;
endmodule

FILE: design/csbm_checker.sv
`include "assert_macros.svh"
// Port-level checks on the core.
module csbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable({rsp_tdata, rsp_tuser}), "rsp dropped while stalled")
   `ASSERT_IMPLY(a_best_ge, clock, reset, rsp_tvalid, $signed(rsp_tdata[51:36]) >= $signed(rsp_tdata[15:0]), "best below current")
   `ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid, "rsp back to back")
   `ASSERT_IMPLY(a_best_idx, clock, reset, rsp_tvalid, rsp_tdata[35:26] <= rsp_tdata[25:16], "best index ahead of key index")
endmodule

bind cosine_similarity_best_match_core csbm_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
